FILE: rtl/cascaded_state_variable_filter_defines.svh
// Assertion macros shared by the filter checker.
`ifndef CASCADED_STATE_VARIABLE_FILTER_DEFINES_SVH
`define CASCADED_STATE_VARIABLE_FILTER_DEFINES_SVH

// Check on every clock edge outside reset.
`define SVF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define SVF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/svf_pkg.sv
// Shared types, constants and arithmetic helpers of the cascaded state-variable filter.
package svf_pkg;

	localparam int MAX_STAGES_DEF = 5;

	localparam int SAMPLE_W   = 24;
	localparam int ACC_W      = 32;
	localparam int COEF_W     = 16;
	localparam int CNT_W      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int PROD_W     = 49;

	typedef enum logic [1:0] {
		MODE_LOW   = 2'd0,
		MODE_HIGH  = 2'd1,
		MODE_BAND  = 2'd2,
		MODE_NOTCH = 2'd3
	} mode_t;

	localparam logic [CFG_IDX_W-1:0] REG_FREQ   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DAMP   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STAGES = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd5;

	localparam logic [COEF_W-1:0] FREQ_RST  = 16'd16384;
	localparam logic [COEF_W-1:0] DAMP_RST  = 16'd32768;
	localparam logic [COEF_W-1:0] SCALE_RST = 16'd46341;
	localparam logic [COEF_W-1:0] GAIN_RST  = 16'd4096;

	typedef struct packed {
		logic [COEF_W-1:0] freq;
		logic [COEF_W-1:0] damp;
		logic [COEF_W-1:0] scale;
		mode_t             mode;
	} svf_coef_t;

	// Round half up and drop 16 fraction bits of a coefficient product.
	function automatic logic signed [32:0] rnd16(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] s;
		s = p + 49'sd32768;
		return s[PROD_W-1:16];
	endfunction

	function automatic logic signed [ACC_W-1:0] sat32(input logic signed [35:0] v);
		if (v > 36'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (v < -36'sd2147483648)
			return 32'sh80000000;
		else
			return v[ACC_W-1:0];
	endfunction

	// Drop the 12 gain fraction bits with rounding, clamp to the sample range.
	function automatic logic signed [SAMPLE_W-1:0] rnd12_sat24(
		input logic signed [PROD_W-1:0] p
	);
		logic signed [PROD_W-1:0] s;
		logic signed [36:0]       r;
		s = p + 49'sd2048;
		r = s[PROD_W-1:12];
		if (r > 37'sd8388607)
			return 24'sh7FFFFF;
		else if (r < -37'sd8388608)
			return 24'sh800000;
		else
			return r[SAMPLE_W-1:0];
	endfunction

endpackage

FILE: rtl/svf_cell.sv
// One state-variable section: holds its low and band integrators and runs one update.
module svf_cell import svf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    clr,
	input  logic                    start,
	input  logic signed [ACC_W-1:0] x_in,
	input  svf_coef_t               coef,
	output logic                    done,
	output logic signed [ACC_W-1:0] y_out
);

	logic signed [16:0] f_s, q_s, g_s;
	logic [3:0]         phase_q;
	logic               done_q;
	logic signed [ACC_W-1:0] low_q, band_q;

	logic signed [PROD_W-1:0] p_fb_q, p_qb_q, p_gx_q, p_fh_q;
	logic signed [33:0]       t_q;
	logic signed [ACC_W-1:0]  high_q, notch_q, y_q;

	logic signed [35:0]      low_sum, high_sum, notch_sum, band_sum;
	logic signed [ACC_W-1:0] band_new;

	assign f_s = {1'b0, coef.freq};
	assign q_s = {1'b0, coef.damp};
	assign g_s = {1'b0, coef.scale};

	assign low_sum   = 36'(low_q) + 36'(rnd16(p_fb_q));
	assign high_sum  = 36'(t_q) - 36'(low_q);
	assign notch_sum = 36'(high_q) + 36'(low_q);
	assign band_sum  = 36'(band_q) + 36'(rnd16(p_fh_q));
	assign band_new  = sat32(band_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			done_q  <= 1'b0;
			low_q   <= '0;
			band_q  <= '0;
		end else begin
			phase_q <= {phase_q[2:0], start};
			done_q  <= phase_q[3];
			if (clr) begin
				low_q  <= '0;
				band_q <= '0;
			end else begin
				if (phase_q[0])
					low_q <= sat32(low_sum);
				if (phase_q[3])
					band_q <= band_new;
			end
		end
	end

	// Products, then low, then high, then f*high and notch, then band and output.
	always_ff @(posedge clk) begin
		if (start) begin
			p_fb_q <= f_s * band_q;
			p_qb_q <= q_s * band_q;
			p_gx_q <= g_s * x_in;
		end
		if (phase_q[0])
			t_q <= 34'(rnd16(p_gx_q)) - 34'(rnd16(p_qb_q));
		if (phase_q[1])
			high_q <= sat32(high_sum);
		if (phase_q[2]) begin
			p_fh_q  <= f_s * high_q;
			notch_q <= sat32(notch_sum);
		end
		if (phase_q[3]) begin
			case (coef.mode)
				MODE_LOW:   y_q <= low_q;
				MODE_HIGH:  y_q <= high_q;
				MODE_BAND:  y_q <= band_new;
				MODE_NOTCH: y_q <= notch_q;
				default:    y_q <= notch_q;
			endcase
		end
	end

	assign done  = done_q;
	assign y_out = y_q;

endmodule

FILE: rtl/cascaded_state_variable_filter.sv
// Top level: chain of filter sections, output gain and saturation, config registers.
//
//  channel  ports                                  direction
//  input    in_valid, in_stall, sample_in          request in
//  output   out_valid, out_stall, sample_out       request out
//  config   cfg_wr_en, cfg_index, cfg_data         write only
//
// Each section runs its update in its own cell, and a request passes through
// N sections (stage_count+1, clamped), the gain product register and the
// output register in that order.
// Only one request runs through the chain at a time; the next is taken once
// the previous result sits in the output register, even while it is stalled.
// Reset clears all integrators and loads the register defaults; a write to
// stage_count clears the integrators too.
module cascaded_state_variable_filter import svf_pkg::*; #(
	parameter int MAX_STAGES = MAX_STAGES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] sample_out,
	input  logic                       cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data
);

	localparam int SECTIONS = MAX_STAGES + 1;
	localparam int IDX_W    = $clog2(SECTIONS);

	logic [COEF_W-1:0] freq_q, damp_q, scale_q, gain_q;
	mode_t             mode_q;
	logic [CNT_W-1:0]  stages_q;
	logic              clr;
	svf_coef_t         coef;

	logic [IDX_W-1:0]  n_eff;
	logic              accept, busy_q;

	logic [SECTIONS-1:0]     start, done, last;
	logic signed [ACC_W-1:0] x_in [SECTIONS];
	logic signed [ACC_W-1:0] y_out [SECTIONS];

	logic                     fin_valid;
	logic signed [ACC_W-1:0]  fin_y;
	logic signed [16:0]       gain_s;
	logic signed [PROD_W-1:0] prod_s1;
	logic                     vld_s1;
	logic                     out_load;
	logic                     out_valid_q;
	logic signed [SAMPLE_W-1:0] out_q;

	// Configuration registers
	assign clr = cfg_wr_en && (cfg_index == REG_STAGES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q   <= FREQ_RST;
			damp_q   <= DAMP_RST;
			scale_q  <= SCALE_RST;
			mode_q   <= MODE_LOW;
			stages_q <= '0;
			gain_q   <= GAIN_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FREQ:   freq_q   <= cfg_data;
				REG_DAMP:   damp_q   <= cfg_data;
				REG_SCALE:  scale_q  <= cfg_data;
				REG_MODE:   mode_q   <= mode_t'(cfg_data[1:0]);
				REG_STAGES: stages_q <= cfg_data[CNT_W-1:0];
				REG_GAIN:   gain_q   <= cfg_data;
				default:    ;
			endcase
		end
	end

	assign coef = '{freq: freq_q, damp: damp_q, scale: scale_q, mode: mode_q};

	always_comb begin
		if (int'(stages_q) > MAX_STAGES)
			n_eff = IDX_W'(MAX_STAGES);
		else
			n_eff = IDX_W'(stages_q);
	end

	assign accept   = in_valid && !busy_q;
	assign in_stall = busy_q;

	// Section chain: each cell hands its output to the next unless it is the last.
	genvar k;
	generate
		for (k = 0; k < SECTIONS; k++) begin : g_cell
			assign last[k] = (n_eff == IDX_W'(k));
			if (k == 0) begin : g_first
				assign start[k] = accept;
				assign x_in[k]  = ACC_W'(sample_in);
			end else begin : g_next
				assign start[k] = done[k-1] && !last[k-1];
				assign x_in[k]  = y_out[k-1];
			end
			svf_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.clr    (clr),
				.start  (start[k]),
				.x_in   (x_in[k]),
				.coef   (coef),
				.done   (done[k]),
				.y_out  (y_out[k])
			);
		end
	endgenerate

	always_comb begin
		fin_valid = 1'b0;
		fin_y     = '0;
		for (int i = 0; i < SECTIONS; i++) begin
			if (done[i] && last[i]) begin
				fin_valid = 1'b1;
				fin_y     = y_out[i];
			end
		end
	end

	assign gain_s   = {1'b0, gain_q};
	assign out_load = vld_s1 && (!out_valid_q || !out_stall);

	always_ff @(posedge clk) begin
		if (fin_valid)
			prod_s1 <= fin_y * gain_s;
		if (out_load)
			out_q <= rnd12_sat24(prod_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				busy_q <= 1'b1;
			else if (out_load)
				busy_q <= 1'b0;
			if (fin_valid)
				vld_s1 <= 1'b1;
			else if (out_load)
				vld_s1 <= 1'b0;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_q;

endmodule

FILE: rtl/svf_checker.sv
// Port-level checker for the cascaded state-variable filter, bound to the top level.
`include "cascaded_state_variable_filter_defines.svh"

module svf_checker import svf_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic signed [SAMPLE_W-1:0] sample_out
);

	`SVF_ASSERT_ALWAYS(a_no_out_in_reset, !arst_n |-> !out_valid, "result shown during reset")

	`SVF_ASSERT(a_one_in_flight, (in_valid && !in_stall) |=> in_stall, "second request taken")

	`SVF_ASSERT(a_no_early_result, (in_valid && !in_stall) |=> !$rose(out_valid), "early result")

	`SVF_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(sample_out)), "result moved")

endmodule

bind cascaded_state_variable_filter svf_checker u_svf_checker (.*);
